>>> hw/rtl/mtmf_pkg.sv
// Package for the multichannel trimmed-mean filter: sizes, queue entry type
// and the reciprocal table used by the back end's divider.
// No dependencies.
`default_nettype none

package mtmf_pkg;

  localparam int CHANNELS     = 4;
  localparam int WINDOW       = 4;
  localparam int SAMPLE_WIDTH = 16;

  // channel field width is fixed by the item format
  localparam int CH_W     = 2;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W    = $clog2(WINDOW);
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int ADDR_W   = $clog2(CHANNELS * WINDOW);
  localparam int SUM_W    = SAMPLE_WIDTH + $clog2(WINDOW);
  localparam int MAG_W    = SUM_W;
  localparam int RCP_W    = MAG_W + 1;
  localparam int PROD_W   = MAG_W + RCP_W;
  localparam int QD_W     = MAG_W + CNT_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam longint unsigned POW2K = 64'd1 << MAG_W;

  typedef struct packed {
    logic [CH_W-1:0]                channel;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [PTR_W-1:0]               ptr;
    logic [CNT_W-1:0]               fill;
  } entry_t;

  // floor(2^MAG_W / d); quotient estimate is low by at most one
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [RCP_W-1:0] r;
    case (int'(d))
      1:       r = RCP_W'(POW2K / 1);
      2:       r = RCP_W'(POW2K / 2);
      3:       r = RCP_W'(POW2K / 3);
      4:       r = RCP_W'(POW2K / 4);
      5:       r = RCP_W'(POW2K / 5);
      6:       r = RCP_W'(POW2K / 6);
      7:       r = RCP_W'(POW2K / 7);
      8:       r = RCP_W'(POW2K / 8);
      9:       r = RCP_W'(POW2K / 9);
      10:      r = RCP_W'(POW2K / 10);
      11:      r = RCP_W'(POW2K / 11);
      12:      r = RCP_W'(POW2K / 12);
      13:      r = RCP_W'(POW2K / 13);
      14:      r = RCP_W'(POW2K / 14);
      15:      r = RCP_W'(POW2K / 15);
      16:      r = RCP_W'(POW2K / 16);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mtmf_if.sv
// Valid/ready channel interfaces for samples in and filtered results out.
// Depends on mtmf_pkg for the channel and sample widths.
`default_nettype none

interface mtmf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [mtmf_pkg::CH_W-1:0]              channel;
  logic signed [mtmf_pkg::SAMPLE_WIDTH-1:0] speed_sample;

  modport source (output valid, output channel, output speed_sample, input ready);
  modport sink   (input valid, input channel, input speed_sample, output ready);
endinterface

interface mtmf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mtmf_pkg::SAMPLE_WIDTH-1:0] filtered_speed;
  logic                                   window_full;

  modport source (output valid, output filtered_speed, output window_full, input ready);
  modport sink   (input valid, input filtered_speed, input window_full, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mtmf_front.sv
// Front end: takes sample items, advances the per-channel write pointer and
// fill count, and pushes a work entry. Depends on mtmf_pkg and mtmf_in_if.
`default_nettype none

module mtmf_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mtmf_in_if.sink          sample_i,
  output mtmf_pkg::entry_t push_data_o,
  output logic             push_valid_o,
  input  wire logic        push_ready_i
);

  logic [mtmf_pkg::PTR_W-1:0]    ptr_q  [mtmf_pkg::CHANNELS];
  logic [mtmf_pkg::CNT_W-1:0]    fill_q [mtmf_pkg::CHANNELS];
  logic [mtmf_pkg::CH_IDX_W-1:0] ch_idx;
  logic                          in_range;
  logic [mtmf_pkg::PTR_W-1:0]    ptr_d;
  logic [mtmf_pkg::CNT_W-1:0]    fill_d;
  logic                          take;

  assign ch_idx   = mtmf_pkg::CH_IDX_W'(sample_i.channel);
  assign in_range = (int'(sample_i.channel) < mtmf_pkg::CHANNELS);

  always_comb begin
    if (ptr_q[ch_idx] == mtmf_pkg::PTR_W'(mtmf_pkg::WINDOW - 1)) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q[ch_idx] + 1'b1;
    end
    if (fill_q[ch_idx] == mtmf_pkg::CNT_W'(mtmf_pkg::WINDOW)) begin
      fill_d = fill_q[ch_idx];
    end else begin
      fill_d = fill_q[ch_idx] + 1'b1;
    end
  end

  // drop items for channels that do not exist
  assign sample_i.ready = push_ready_i;
  assign push_valid_o   = sample_i.valid && in_range;
  assign take           = push_valid_o && push_ready_i;

  assign push_data_o.channel = sample_i.channel;
  assign push_data_o.sample  = sample_i.speed_sample;
  assign push_data_o.ptr     = ptr_q[ch_idx];
  assign push_data_o.fill    = fill_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < mtmf_pkg::CHANNELS; c++) begin
        ptr_q[c]  <= '0;
        fill_q[c] <= '0;
      end
    end else if (take) begin
      ptr_q[ch_idx]  <= ptr_d;
      fill_q[ch_idx] <= fill_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mtmf_queue.sv
// Short FIFO of work entries between the front and back ends.
// Depends on mtmf_pkg.
`default_nettype none

module mtmf_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire mtmf_pkg::entry_t  push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output mtmf_pkg::entry_t       pop_data_o
);

  mtmf_pkg::entry_t              slot_q [mtmf_pkg::QUEUE_DEPTH];
  logic [mtmf_pkg::QPTR_W-1:0]   wr_q, rd_q;
  logic [mtmf_pkg::QCNT_W-1:0]   count_q;
  logic                          push, pop;

  assign push_ready_o = (count_q != mtmf_pkg::QCNT_W'(mtmf_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [mtmf_pkg::QPTR_W-1:0] wrap_inc(
      input logic [mtmf_pkg::QPTR_W-1:0] p);
    logic [mtmf_pkg::QPTR_W-1:0] n;
    if (p == mtmf_pkg::QPTR_W'(mtmf_pkg::QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wrap_inc(wr_q);
      end
      if (pop) begin
        rd_q <= wrap_inc(rd_q);
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mtmf_back.sv
// Back end: stores the sample, scans the channel's window for sum, max and
// min, divides by reciprocal multiply with one correction, holds the result.
// Depends on mtmf_pkg and mtmf_out_if.
`default_nettype none

module mtmf_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pop_valid_i,
  output logic                  pop_ready_o,
  input  wire mtmf_pkg::entry_t pop_data_i,
  mtmf_out_if.source            result_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_PREP = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIX  = 5'b10000
  } state_e;

  localparam int SW = mtmf_pkg::SAMPLE_WIDTH;

  state_e                               state_q, state_d;
  logic signed [SW-1:0]                 mem [mtmf_pkg::CHANNELS * mtmf_pkg::WINDOW];
  logic signed [SW-1:0]                 rd_data_q;
  logic [mtmf_pkg::ADDR_W-1:0]          wr_addr, rd_addr;
  logic [mtmf_pkg::CH_W-1:0]            ch_q;
  logic [mtmf_pkg::CNT_W-1:0]           n_q, cnt_q, elem;
  logic signed [mtmf_pkg::SUM_W-1:0]    sum_q, num;
  logic signed [SW-1:0]                 hi_q, lo_q;
  logic                                 full, full_q, neg_q;
  logic [mtmf_pkg::MAG_W-1:0]           mag_q, q_est, q_fix;
  logic [mtmf_pkg::CNT_W-1:0]           div_q;
  logic [mtmf_pkg::RCP_W-1:0]           rcp_q;
  logic [mtmf_pkg::PROD_W-1:0]          prod_q;
  logic [mtmf_pkg::QD_W-1:0]            qd, rem;
  logic [mtmf_pkg::MAG_W-1:0]           res;
  logic                                 out_free, scan_done;
  logic                                 out_valid_q, out_full_q;
  logic signed [SW-1:0]                 out_speed_q;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign wr_addr = mtmf_pkg::ADDR_W'(int'(pop_data_i.channel) * mtmf_pkg::WINDOW
                                     + int'(pop_data_i.ptr));
  assign rd_addr = mtmf_pkg::ADDR_W'(int'(ch_q) * mtmf_pkg::WINDOW
                                     + int'(cnt_q[mtmf_pkg::PTR_W-1:0]));
  assign elem      = cnt_q - 1'b1;
  assign scan_done = (cnt_q == mtmf_pkg::CNT_W'(mtmf_pkg::WINDOW));
  assign full      = (n_q == mtmf_pkg::CNT_W'(mtmf_pkg::WINDOW));
  assign out_free  = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pop_valid_i) begin
      mem[wr_addr] <= pop_data_i.sample;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (pop_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (scan_done)   state_d = ST_PREP;
      ST_PREP: state_d = ST_MUL;
      ST_MUL:  state_d = ST_FIX;
      ST_FIX:  if (out_free)    state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // trimmed numerator drops the extremes once the window is full
  assign num = full ? (sum_q - mtmf_pkg::SUM_W'(hi_q) - mtmf_pkg::SUM_W'(lo_q)) : sum_q;

  assign q_est = mtmf_pkg::MAG_W'(prod_q[mtmf_pkg::PROD_W-1:mtmf_pkg::MAG_W]);
  assign qd    = mtmf_pkg::QD_W'(q_est) * mtmf_pkg::QD_W'(div_q);
  assign rem   = mtmf_pkg::QD_W'(mag_q) - qd;
  assign q_fix = (rem >= mtmf_pkg::QD_W'(div_q)) ? q_est + 1'b1 : q_est;
  assign res   = neg_q ? (~q_fix + 1'b1) : q_fix;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        ch_q <= pop_data_i.channel;
        n_q  <= pop_data_i.fill;
      end
      ST_SCAN: begin
        // data for element cnt-1 is registered and arrives in the cycle after its address
        if (cnt_q == mtmf_pkg::CNT_W'(1)) begin
          sum_q <= mtmf_pkg::SUM_W'(rd_data_q);
          hi_q  <= rd_data_q;
          lo_q  <= rd_data_q;
        end else if (cnt_q != '0) begin
          if (elem < n_q) begin
            sum_q <= sum_q + mtmf_pkg::SUM_W'(rd_data_q);
          end
          if (rd_data_q > hi_q) hi_q <= rd_data_q;
          if (rd_data_q < lo_q) lo_q <= rd_data_q;
        end
      end
      ST_PREP: begin
        neg_q  <= num[mtmf_pkg::SUM_W-1];
        mag_q  <= num[mtmf_pkg::SUM_W-1] ? mtmf_pkg::MAG_W'(-num) : mtmf_pkg::MAG_W'(num);
        div_q  <= full ? mtmf_pkg::CNT_W'(mtmf_pkg::WINDOW - 2) : n_q;
        rcp_q  <= mtmf_pkg::recip(full ? mtmf_pkg::CNT_W'(mtmf_pkg::WINDOW - 2) : n_q);
        full_q <= full;
      end
      ST_MUL: begin
        prod_q <= mtmf_pkg::PROD_W'(mag_q) * mtmf_pkg::PROD_W'(rcp_q);
      end
      ST_FIX: begin
        if (out_free) begin
          out_speed_q <= SW'(res);
          out_full_q  <= full_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SCAN) begin
        cnt_q <= scan_done ? '0 : cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == ST_FIX && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.filtered_speed = out_speed_q;
  assign result_o.window_full    = out_full_q;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIX |-> div_q != '0)
    else $error("divisor is zero at quotient correction");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIX |-> rem < (mtmf_pkg::QD_W'(div_q) << 1))
    else $error("reciprocal estimate off by more than one");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> cnt_q <= mtmf_pkg::CNT_W'(mtmf_pkg::WINDOW))
    else $error("window scan ran past the window");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PREP |-> (n_q != '0) && (n_q <= mtmf_pkg::CNT_W'(mtmf_pkg::WINDOW)))
    else $error("fill count out of range");

  a_scan_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && scan_done |=> state_q == ST_PREP)
    else $error("scan end did not reach numerator stage");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/multichannel_trimmed_mean_filter.sv
// The back end works on one sample at a time; it scans the channel's window
// serially through the single read port of the sample memory.
// The front end and a two-entry queue take up to two samples ahead of the back.
// Reset clears pointers, fill counts, queue and control; the sample memory is
// not cleared, so the block is ready right after reset.
`default_nettype none

module multichannel_trimmed_mean_filter (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mtmf_in_if.sink    sample_i,
  mtmf_out_if.source result_o
);

  mtmf_pkg::entry_t push_data, pop_data;
  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;

  mtmf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  mtmf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mtmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
